### hw/rtl/mipid_pkg.sv
// Shared types and constants for the multichannel incremental PID block.
// Used by the modules under hw/rtl except mipid_ram; depends on nothing.
package mipid_pkg;

  localparam int CHANNELS_DEF  = 4;
  localparam int FRAC_BITS_DEF = 8;

  localparam int CH_W   = 2;
  localparam int MEAS_W = 16;
  localparam int GAIN_W = 16;
  localparam int DB_W   = 8;
  localparam int DUTY_W = 12;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  // error, second difference, product and sum widths
  localparam int E_W    = MEAS_W + 1;
  localparam int DIFF_W = E_W + 2;
  localparam int PROD_W = GAIN_W + 1 + DIFF_W;
  localparam int SUM_W  = PROD_W + 2;

  localparam int OQ_AW    = 3;
  localparam int OQ_DEPTH = 1 << OQ_AW;

  localparam logic [DB_W-1:0]   DEAD_BAND_RST  = 8'd5;
  localparam logic [DUTY_W-1:0] DUTY_LIMIT_RST = 12'd1000;

  typedef enum logic [CFG_AW-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_DEAD_BAND  = 3'd3,
    REG_DUTY_LIMIT = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic [DB_W-1:0]   dead_band;
    logic [DUTY_W-1:0] duty_limit;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]          channel;
    logic signed [MEAS_W-1:0] measured;
    logic signed [MEAS_W-1:0] setpoint;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]   channel_out;
    logic [DUTY_W-1:0] duty;
  } out_item_t;

endpackage

### hw/rtl/multichannel_incremental_pid.sv
// Top level of the multichannel incremental PID; holds the update pipeline.
// Depends on mipid_pkg, mipid_ram, mipid_cfg and mipid_outq.
//
// One item per clock is taken in steady state while in_stall is low, for any mix of
// channels. Each item runs through a five-stage pipeline: error history read,
// differences and history write-back, gain products, product sum with accumulator
// read, accumulate/clamp with accumulator write. The result then goes through the
// result queue to out_valid. Per-channel state lives in two RAMs with registered
// read, with forwarding between items on the same channel. An eight-entry result
// queue absorbs output stalls; in_stall rises when eight items are in flight or
// waiting. Channel state is zero after reset, with no clearing pass.
module multichannel_incremental_pid #(
  parameter int CHANNELS  = mipid_pkg::CHANNELS_DEF,
  parameter int FRAC_BITS = mipid_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  mipid_pkg::in_item_t           in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output mipid_pkg::out_item_t          out_data,
  input  logic                          cfg_we,
  input  logic [mipid_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [mipid_pkg::CFG_DW-1:0]  cfg_wdata
);

  localparam int CH_AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_W   = mipid_pkg::CH_W;
  localparam int E_W    = mipid_pkg::E_W;
  localparam int DIFF_W = mipid_pkg::DIFF_W;
  localparam int PROD_W = mipid_pkg::PROD_W;
  localparam int SUM_W  = mipid_pkg::SUM_W;
  localparam int DUTY_W = mipid_pkg::DUTY_W;
  localparam int ACC_W  = DUTY_W + FRAC_BITS;
  localparam int CNT_W  = mipid_pkg::OQ_AW + 1;

  mipid_pkg::cfg_t cfg;

  mipid_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // occupancy: items accepted and not yet delivered
  logic             in_acc, out_pop;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (cnt_r == CNT_W'(mipid_pkg::OQ_DEPTH));
  assign cnt_nxt  = cnt_r + CNT_W'(in_acc) - CNT_W'(out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // stage B: error history available
  logic                  b_vld_r, b_rng_r;
  logic [CH_W-1:0]       b_ch_r;
  logic signed [E_W-1:0] b_e_r, b_e_nxt;

  assign b_e_nxt = E_W'(in_data.setpoint) - E_W'(in_data.measured);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= in_acc;
    end
    b_ch_r  <= in_data.channel;
    b_rng_r <= (int'(in_data.channel) < CHANNELS);
    b_e_r   <= b_e_nxt;
  end

  logic [CH_AW-1:0]      b_idx;
  logic [2*E_W-1:0]      err_rdata, err_cur, err_wdata;
  logic                  err_we;
  logic [CHANNELS-1:0]   errv_r, errv_nxt;
  logic                  fe_vld_r;
  logic [CH_AW-1:0]      fe_idx_r;
  logic [2*E_W-1:0]      fe_data_r;
  logic signed [E_W-1:0] e1, e2;
  logic [E_W-1:0]        mag;
  logic                  b_upd;
  logic signed [DIFF_W-1:0] dp, dd;

  assign b_idx = CH_AW'(b_ch_r);

  mipid_ram #(.WIDTH(2*E_W), .DEPTH(CHANNELS)) u_err_ram (
    .clk   (clk),
    .we    (err_we),
    .waddr (b_idx),
    .wdata (err_wdata),
    .raddr (CH_AW'(in_data.channel)),
    .rdata (err_rdata)
  );

  always_comb begin
    if (fe_vld_r && fe_idx_r == b_idx) begin
      err_cur = fe_data_r;
    end else if (errv_r[b_idx]) begin
      err_cur = err_rdata;
    end else begin
      err_cur = '0;
    end
  end

  assign e1    = err_cur[2*E_W-1:E_W];
  assign e2    = err_cur[E_W-1:0];
  assign mag   = b_e_r[E_W-1] ? E_W'(-b_e_r) : E_W'(b_e_r);
  assign b_upd = b_rng_r && (mag > E_W'(cfg.dead_band));
  assign dp    = DIFF_W'(b_e_r) - DIFF_W'(e1);
  assign dd    = DIFF_W'(b_e_r) - (DIFF_W'(e1) <<< 1) + DIFF_W'(e2);

  assign err_we    = b_vld_r && b_upd;
  assign err_wdata = {b_e_r, e1};

  always_comb begin
    errv_nxt = errv_r;
    if (err_we) begin
      errv_nxt[b_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      errv_r   <= '0;
      fe_vld_r <= 1'b0;
    end else begin
      errv_r   <= errv_nxt;
      fe_vld_r <= err_we;
    end
    fe_idx_r  <= b_idx;
    fe_data_r <= err_wdata;
  end

  // stage C: gain products
  logic                     c_vld_r, c_rng_r, c_upd_r;
  logic [CH_W-1:0]          c_ch_r;
  logic signed [E_W-1:0]    c_e_r;
  logic signed [DIFF_W-1:0] c_dp_r, c_dd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= b_vld_r;
    end
    c_ch_r  <= b_ch_r;
    c_rng_r <= b_rng_r;
    c_upd_r <= b_upd;
    c_e_r   <= b_e_r;
    c_dp_r  <= dp;
    c_dd_r  <= dd;
  end

  logic signed [PROD_W-1:0] p_nxt, i_nxt, d_nxt;

  assign p_nxt = $signed({1'b0, cfg.prop_gain})  * c_dp_r;
  assign i_nxt = $signed({1'b0, cfg.integ_gain}) * DIFF_W'(c_e_r);
  assign d_nxt = $signed({1'b0, cfg.deriv_gain}) * c_dd_r;

  // stage D: sum of products, accumulator read issued
  logic                     d_vld_r, d_rng_r, d_upd_r;
  logic [CH_W-1:0]          d_ch_r;
  logic signed [PROD_W-1:0] d_p_r, d_i_r, d_d_r;
  logic signed [SUM_W-1:0]  psum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else begin
      d_vld_r <= c_vld_r;
    end
    d_ch_r  <= c_ch_r;
    d_rng_r <= c_rng_r;
    d_upd_r <= c_upd_r;
    d_p_r   <= p_nxt;
    d_i_r   <= i_nxt;
    d_d_r   <= d_nxt;
  end

  assign psum_nxt = d_upd_r ? (SUM_W'(d_p_r) + SUM_W'(d_i_r) + SUM_W'(d_d_r)) : '0;

  // stage E: accumulate, clamp, write back
  logic                    e_vld_r, e_rng_r;
  logic [CH_W-1:0]         e_ch_r;
  logic signed [SUM_W-1:0] e_psum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else begin
      e_vld_r <= d_vld_r;
    end
    e_ch_r   <= d_ch_r;
    e_rng_r  <= d_rng_r;
    e_psum_r <= psum_nxt;
  end

  logic [CH_AW-1:0]        e_idx;
  logic [ACC_W-1:0]        acc_rdata, acc_old, acc_new, acc_top;
  logic signed [SUM_W-1:0] acc_sum, top_s;
  logic                    acc_we;
  logic [CHANNELS-1:0]     accv_r, accv_nxt;
  logic                    fa_vld_r;
  logic [CH_AW-1:0]        fa_idx_r;
  logic [ACC_W-1:0]        fa_val_r;
  mipid_pkg::out_item_t    res;

  assign e_idx = CH_AW'(e_ch_r);

  mipid_ram #(.WIDTH(ACC_W), .DEPTH(CHANNELS)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (e_idx),
    .wdata (acc_new),
    .raddr (CH_AW'(d_ch_r)),
    .rdata (acc_rdata)
  );

  always_comb begin
    if (fa_vld_r && fa_idx_r == e_idx) begin
      acc_old = fa_val_r;
    end else if (accv_r[e_idx]) begin
      acc_old = acc_rdata;
    end else begin
      acc_old = '0;
    end
  end

  assign acc_top = ACC_W'(cfg.duty_limit) << FRAC_BITS;
  assign top_s   = $signed(SUM_W'(acc_top));
  assign acc_sum = $signed(SUM_W'(acc_old)) + e_psum_r;

  always_comb begin
    priority if (acc_sum[SUM_W-1] || acc_sum == '0) begin
      acc_new = '0;
    end else if (acc_sum >= top_s) begin
      acc_new = acc_top;
    end else begin
      acc_new = acc_sum[ACC_W-1:0];
    end
  end

  assign acc_we = e_vld_r && e_rng_r;

  always_comb begin
    accv_nxt = accv_r;
    if (acc_we) begin
      accv_nxt[e_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accv_r   <= '0;
      fa_vld_r <= 1'b0;
    end else begin
      accv_r   <= accv_nxt;
      fa_vld_r <= acc_we;
    end
    fa_idx_r <= e_idx;
    fa_val_r <= acc_new;
  end

  assign res.channel_out = e_ch_r;
  assign res.duty        = e_rng_r ? acc_new[ACC_W-1 -: DUTY_W] : '0;

  assign out_pop = out_valid && !out_stall;

  mipid_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (e_vld_r),
    .push_item (res),
    .pop       (out_pop),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

endmodule

### hw/rtl/mipid_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Read during write to the same address returns the old data. No dependencies.
module mipid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/mipid_cfg.sv
// Configuration register file: gains, deadband and duty limit.
// Depends on mipid_pkg.
module mipid_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mipid_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [mipid_pkg::CFG_DW-1:0]  cfg_wdata,
  output mipid_pkg::cfg_t               cfg
);

  mipid_pkg::cfg_t cfg_r;
  mipid_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        mipid_pkg::REG_PROP_GAIN:  cfg_nxt.prop_gain  = cfg_wdata;
        mipid_pkg::REG_INTEG_GAIN: cfg_nxt.integ_gain = cfg_wdata;
        mipid_pkg::REG_DERIV_GAIN: cfg_nxt.deriv_gain = cfg_wdata;
        mipid_pkg::REG_DEAD_BAND:  cfg_nxt.dead_band  = cfg_wdata[mipid_pkg::DB_W-1:0];
        mipid_pkg::REG_DUTY_LIMIT: cfg_nxt.duty_limit = cfg_wdata[mipid_pkg::DUTY_W-1:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain  <= '0;
      cfg_r.integ_gain <= '0;
      cfg_r.deriv_gain <= '0;
      cfg_r.dead_band  <= mipid_pkg::DEAD_BAND_RST;
      cfg_r.duty_limit <= mipid_pkg::DUTY_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### hw/rtl/mipid_outq.sv
// Result queue between the update pipeline and the output channel.
// Depends on mipid_pkg.
module mipid_outq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  mipid_pkg::out_item_t  push_item,
  input  logic                  pop,
  output logic                  out_valid,
  output mipid_pkg::out_item_t  out_item
);

  localparam int AW = mipid_pkg::OQ_AW;

  mipid_pkg::out_item_t q_r [mipid_pkg::OQ_DEPTH];
  logic [AW:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW:0] rd_ptr_r, rd_ptr_nxt;

  assign wr_ptr_nxt = wr_ptr_r + (AW+1)'(push);
  assign rd_ptr_nxt = rd_ptr_r + (AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r[AW-1:0]] <= push_item;
    end
  end

  assign out_valid = (wr_ptr_r != rd_ptr_r);
  assign out_item  = q_r[rd_ptr_r[AW-1:0]];

endmodule

### verif/tb_multichannel_incremental_pid.sv
// Self-checking testbench for multichannel_incremental_pid: directed and random items,
// with a per-channel velocity-form PID predictor checking every duty result in order.
// Depends on mipid_pkg and the RTL under hw/rtl.
module tb_multichannel_incremental_pid;
  timeunit 1ns;
  timeprecision 1ps;

  import mipid_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int QUIET_TAIL     = 150;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;

  // predictor copy of the configuration and channel state
  int     kp_q  = 0;
  int     ki_q  = 0;
  int     kd_q  = 0;
  int     db_q  = int'(DEAD_BAND_RST);
  int     lim_q = int'(DUTY_LIMIT_RST);
  int     ch_prev_err[CHANNELS_DEF];
  int     ch_older_err[CHANNELS_DEF];
  longint ch_accum[CHANNELS_DEF];

  out_item_t duty_expected[$];
  int        fail_count   = 0;
  int        quiet_cycles = 0;
  int        stall_left   = 0;
  bit        idle_on      = 1'b1;

  multichannel_incremental_pid DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  function automatic out_item_t predict_duty(input in_item_t item);
    out_item_t res;
    int        ch;
    int        err;
    int        mag;
    int        e1;
    int        e2;
    longint    acc;
    longint    top;
    ch = int'(item.channel);
    res.channel_out = item.channel;
    res.duty = '0;
    if (ch >= CHANNELS_DEF) return res;
    err = int'($signed(item.setpoint)) - int'($signed(item.measured));
    mag = (err < 0) ? -err : err;
    acc = ch_accum[ch];
    if (mag > db_q) begin
      e1 = ch_prev_err[ch];
      e2 = ch_older_err[ch];
      acc += longint'(kp_q) * (err - e1) + longint'(ki_q) * err
           + longint'(kd_q) * (err - 2 * e1 + e2);
      ch_older_err[ch] = e1;
      ch_prev_err[ch]  = err;
    end
    top = longint'(lim_q) << FRAC_BITS_DEF;
    if (acc >= top) acc = top;
    if (acc <= 0) acc = 0;
    ch_accum[ch] = acc;
    res.duty = DUTY_W'(acc >> FRAC_BITS_DEF);
    return res;
  endfunction

  function automatic in_item_t make_item(input int ch, input int meas, input int sp);
    in_item_t item;
    item.channel  = ch[CH_W-1:0];
    item.measured = meas[MEAS_W-1:0];
    item.setpoint = sp[MEAS_W-1:0];
    return item;
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(0, 600));
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PROP_GAIN:  kp_q  = int'(val);
      REG_INTEG_GAIN: ki_q  = int'(val);
      REG_DERIV_GAIN: kd_q  = int'(val);
      REG_DEAD_BAND:  db_q  = int'(val[DB_W-1:0]);
      REG_DUTY_LIMIT: lim_q = int'(val[DUTY_W-1:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_item(input in_item_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    duty_expected.push_back(predict_duty(item));
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // pipeline drained and quiet before any register write
  task automatic settle();
    in_valid <= 1'b0;
    while (duty_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    write_reg(REG_PROP_GAIN, 16'd256);
    write_reg(REG_INTEG_GAIN, 16'd256);
    send_item(make_item(0, 0, 5));
    send_item(make_item(0, 0, 6));
    send_item(make_item(1, 6, 0));
    send_item(make_item(2, -15000, 15000));
  endtask

  task automatic test_field_extremes();
    settle();
    write_reg(REG_PROP_GAIN, 16'hFFFF);
    write_reg(REG_INTEG_GAIN, 16'hFFFF);
    write_reg(REG_DERIV_GAIN, 16'hFFFF);
    write_reg(REG_DEAD_BAND, 16'h0000);
    write_reg(REG_DUTY_LIMIT, 16'hFFFF);
    send_item(make_item(3, -32768, 32767));
    send_item(make_item(3, 32767, -32768));
    send_item(make_item(0, 0, 0));
    send_item(make_item(1, -32768, -32768));
    send_item(make_item(2, 32767, 32767));
    send_item(make_item(0, 0, 1));
  endtask

  task automatic test_dead_band_edges();
    settle();
    write_reg(REG_PROP_GAIN, 16'd0);
    write_reg(REG_INTEG_GAIN, 16'd256);
    write_reg(REG_DERIV_GAIN, 16'd0);
    write_reg(REG_DEAD_BAND, 16'h00FF);
    write_reg(REG_DUTY_LIMIT, 16'd4095);
    send_item(make_item(0, 0, 255));
    send_item(make_item(0, 255, 0));
    send_item(make_item(0, 0, 256));
    send_item(make_item(0, 256, 0));
    send_item(make_item(0, 0, 257));
  endtask

  task automatic test_limit_lowered();
    settle();
    write_reg(REG_DEAD_BAND, 16'd0);
    write_reg(REG_INTEG_GAIN, 16'hFFFF);
    send_item(make_item(1, -1000, 0));
    settle();
    write_reg(REG_DUTY_LIMIT, 16'd100);
    send_item(make_item(1, 0, 0));
    settle();
    write_reg(REG_DUTY_LIMIT, 16'd0);
    send_item(make_item(1, 5, 5));
  endtask

  task automatic test_unknown_regs();
    settle();
    write_reg(REG_DUTY_LIMIT, 16'd2000);
    for (int i = int'(REG_DUTY_LIMIT) + 1; i < (1 << CFG_AW); i++) begin
      write_reg(i[CFG_AW-1:0], 16'hFFFF);
    end
    send_item(make_item(2, 0, 300));
    send_item(make_item(2, 300, 0));
  endtask

  task automatic test_random_traffic(input int n_items);
    int         sent;
    int         k;
    int         kind;
    int         ch;
    int         sp;
    int         meas;
    int         err;
    int         track_sp[CHANNELS_DEF];
    logic [7:0]  db8;
    logic [11:0] lim12;
    sent = 0;
    while (sent < n_items) begin
      settle();
      write_reg(REG_PROP_GAIN, pick_gain());
      write_reg(REG_INTEG_GAIN, pick_gain());
      write_reg(REG_DERIV_GAIN, pick_gain());
      case ($urandom_range(0, 3))
        0: db8 = '0;
        1: db8 = '1;
        default: db8 = 8'($urandom_range(0, 40));
      endcase
      write_reg(REG_DEAD_BAND, {8'($urandom), db8});
      case ($urandom_range(0, 4))
        0: lim12 = '0;
        1: lim12 = '1;
        default: lim12 = 12'($urandom_range(1, 4095));
      endcase
      write_reg(REG_DUTY_LIMIT, {4'($urandom), lim12});
      foreach (track_sp[i]) track_sp[i] = $urandom_range(0, 4000) - 2000;
      idle_on = (n_items - sent > QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      for (k = 0; k < 60 && sent < n_items; k++) begin
        kind = $urandom_range(0, 99);
        ch   = $urandom_range(0, CHANNELS_DEF - 1);
        if (kind < 70) begin
          sp   = track_sp[ch];
          meas = sp + $urandom_range(0, 600) - 300;
        end else if (kind < 85) begin
          // errors straddling the deadband edge
          err = db_q + $urandom_range(0, 4) - 2;
          if ($urandom_range(0, 1)) err = -err;
          sp   = $urandom_range(0, 2000) - 1000;
          meas = sp - err;
        end else begin
          sp   = $urandom;
          meas = $urandom;
        end
        send_item(make_item(ch, meas, sp));
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (duty_expected.size() == 0) begin
        flag_error($sformatf("unexpected item: channel_out=%0d duty=%0d",
                             out_data.channel_out, out_data.duty));
      end else begin
        want = duty_expected.pop_front();
        if (out_data.channel_out !== want.channel_out || out_data.duty !== want.duty) begin
          flag_error($sformatf("mismatch: expected channel_out=%0d duty=%0d, got %0d %0d",
                               want.channel_out, want.duty,
                               out_data.channel_out, out_data.duty));
        end
      end
    end
    if (idle_on && stall_left == 0 && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 19);
    end
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_field_extremes();
    test_dead_band_edges();
    test_limit_lowered();
    test_unknown_regs();
    test_random_traffic(900);

    in_valid <= 1'b0;
    while (duty_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (duty_expected.size() != 0) begin
      flag_error($sformatf("%0d items never arrived", duty_expected.size()));
    end
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
